[src/pisc_pkg.sv]
`default_nettype none

package pisc_pkg;

  localparam int NUM_MASKS   = 6;
  localparam int NUM_FLAGS   = 3;
  localparam int CFG_INDEX_W = 3;

  localparam logic [7:0] MASK_BASE_ADDR_DEF   = 8'd16;
  localparam logic [7:0] FLAG_BASE_ADDR_DEF   = 8'd8;
  localparam logic [7:0] FLAG0_VALID_BITS_DEF = 8'hFF;
  localparam logic [7:0] FLAG1_VALID_BITS_DEF = 8'hFF;
  localparam logic [7:0] FLAG2_VALID_BITS_DEF = 8'h7F;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef logic [NUM_MASKS-1:0][7:0] mask_set_t;
  typedef logic [NUM_FLAGS-1:0][7:0] flag_set_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        host_irq;
    logic [23:0] local_dispatch;
    logic        update_request;
    logic [7:0]  effective_mask;
  } rsp_t;

  // One enable bit per flag (reg*8+bit) for a set of six mask bytes.
  function automatic flag_set_t flag_enables(input mask_set_t m);
    flag_set_t en;
    en[0] = ~m[0];
    en[1] = ~m[1];
    en[2] = ~m[2];
    en[1][7] = (|(~m[3][3:0])) | (|(~m[4])) | (|(~m[5][4:0]));
    en[1][1] = ~m[1][2];
    en[0][4] = ~m[0][3];
    return en;
  endfunction

endpackage

`default_nettype wire

[src/pisc_if.sv]
`default_nettype none

interface pisc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] reg_address;
  logic [7:0] write_value;
  logic [7:0] raw_flags_low;
  logic [7:0] raw_flags_mid;
  logic [7:0] raw_flags_high;

  modport source (output valid, command, reg_address, write_value,
                  raw_flags_low, raw_flags_mid, raw_flags_high, input ready);
  modport sink   (input valid, command, reg_address, write_value,
                  raw_flags_low, raw_flags_mid, raw_flags_high, output ready);
endinterface

interface pisc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        host_irq;
  logic [23:0] local_dispatch;
  logic        update_request;
  logic [7:0]  effective_mask;

  modport source (output valid, read_data, host_irq, local_dispatch,
                  update_request, effective_mask, input ready);
  modport sink   (input valid, read_data, host_irq, local_dispatch,
                  update_request, effective_mask, output ready);
endinterface

`default_nettype wire

[src/pisc_out_buf.sv]
`default_nettype none

// Two-entry result queue: takes a new result while the head one is stalled.
module pisc_out_buf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pisc_pkg::rsp_t push_data,
  output logic               can_push,
  output logic               head_valid,
  output pisc_pkg::rsp_t     head_data,
  input  wire logic          pop
);

  pisc_pkg::rsp_t slot0;
  pisc_pkg::rsp_t slot1;
  logic [1:0]     count;
  logic           do_pop;
  logic           push_head;

  assign can_push   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = slot0;
  assign do_pop     = pop && head_valid;
  assign push_head  = push && (count == 2'd0 || (count == 2'd1 && do_pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    priority if (push_head) begin
      slot0 <= push_data;
    end else if (do_pop) begin
      slot0 <= slot1;
    end
    if (push && !push_head) begin
      slot1 <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/pmic_interrupt_shadow_controller.sv]
`default_nettype none

// Interrupt shadow controller between a power chip and a host. One item is
// accepted per cycle; its result is registered into a two-entry result
// queue, so input is refused only when two results wait unread. Events OR
// the chip flags (reserved bits dropped) into three sticky host flag bytes,
// report locally enabled flags in local_dispatch and raise host_irq when
// the host masks enable any set flag. Host reads return a mask byte, or
// return and clear a flag byte (host_irq drops once all flags are zero);
// host writes load a mask byte and return the local AND host mask. The user
// must write local masks via the cfg port only while no item is in flight.
module pmic_interrupt_shadow_controller #(
  parameter logic [7:0] MASK_BASE_ADDR   = pisc_pkg::MASK_BASE_ADDR_DEF,
  parameter logic [7:0] FLAG_BASE_ADDR   = pisc_pkg::FLAG_BASE_ADDR_DEF,
  parameter logic [7:0] FLAG0_VALID_BITS = pisc_pkg::FLAG0_VALID_BITS_DEF,
  parameter logic [7:0] FLAG1_VALID_BITS = pisc_pkg::FLAG1_VALID_BITS_DEF,
  parameter logic [7:0] FLAG2_VALID_BITS = pisc_pkg::FLAG2_VALID_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [pisc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  pisc_req_if.sink                              request,
  pisc_rsp_if.source                            result
);

  pisc_pkg::mask_set_t local_mask;
  pisc_pkg::mask_set_t host_mask;
  pisc_pkg::mask_set_t host_mask_next;
  pisc_pkg::flag_set_t host_flags;
  pisc_pkg::flag_set_t host_flags_next;
  logic                irq_level;
  logic                irq_level_next;

  pisc_pkg::flag_set_t raw;
  pisc_pkg::flag_set_t valid_flags;
  pisc_pkg::flag_set_t local_en;
  pisc_pkg::flag_set_t host_en;
  pisc_pkg::rsp_t      rsp;
  logic                accept;
  logic                can_push;
  logic [7:0]          mask_off;
  logic [7:0]          flag_off;
  logic                is_mask;
  logic                is_flag;
  logic [2:0]          mask_idx;
  logic [1:0]          flag_idx;

  assign accept = request.valid && request.ready;

  assign mask_off = request.reg_address - MASK_BASE_ADDR;
  assign flag_off = request.reg_address - FLAG_BASE_ADDR;
  assign is_mask  = (request.reg_address >= MASK_BASE_ADDR) &&
                    (mask_off < 8'(pisc_pkg::NUM_MASKS));
  assign is_flag  = (request.reg_address >= FLAG_BASE_ADDR) &&
                    (flag_off < 8'(pisc_pkg::NUM_FLAGS));
  assign mask_idx = mask_off[2:0];
  assign flag_idx = flag_off[1:0];

  assign raw = {request.raw_flags_high, request.raw_flags_mid, request.raw_flags_low};
  assign valid_flags = raw & {FLAG2_VALID_BITS, FLAG1_VALID_BITS, FLAG0_VALID_BITS};
  assign local_en    = pisc_pkg::flag_enables(local_mask);
  assign host_en     = pisc_pkg::flag_enables(host_mask);

  always_comb begin
    host_mask_next  = host_mask;
    host_flags_next = host_flags;
    irq_level_next  = irq_level;
    rsp             = '0;
    unique case (pisc_pkg::cmd_t'(request.command))
      pisc_pkg::CMD_EVENT: begin
        host_flags_next    = host_flags | valid_flags;
        rsp.local_dispatch = valid_flags & local_en;
        if (|(valid_flags & host_en)) begin
          irq_level_next = 1'b1;
        end
      end
      pisc_pkg::CMD_READ: begin
        priority if (is_mask) begin
          rsp.read_data = host_mask[mask_idx];
        end else if (is_flag) begin
          rsp.read_data             = host_flags[flag_idx];
          host_flags_next[flag_idx] = 8'd0;
          if (host_flags_next == '0) begin
            irq_level_next = 1'b0;
          end
        end else begin
          rsp.read_data = 8'd0;
        end
      end
      pisc_pkg::CMD_WRITE: begin
        if (is_mask) begin
          host_mask_next[mask_idx] = request.write_value;
          rsp.update_request       = 1'b1;
          rsp.effective_mask       = local_mask[mask_idx] & request.write_value;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
    rsp.host_irq = irq_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_mask <= '1;
      host_mask  <= '1;
      host_flags <= '0;
      irq_level  <= 1'b0;
    end else begin
      if (cfg_write_en && (cfg_index < pisc_pkg::CFG_INDEX_W'(pisc_pkg::NUM_MASKS))) begin
        local_mask[cfg_index] <= cfg_data;
      end
      if (accept) begin
        host_mask  <= host_mask_next;
        host_flags <= host_flags_next;
        irq_level  <= irq_level_next;
      end
    end
  end

  pisc_pkg::rsp_t head;

  pisc_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (rsp),
    .can_push   (can_push),
    .head_valid (result.valid),
    .head_data  (head),
    .pop        (result.ready)
  );

  assign request.ready         = can_push;
  assign result.read_data      = head.read_data;
  assign result.host_irq       = head.host_irq;
  assign result.local_dispatch = head.local_dispatch;
  assign result.update_request = head.update_request;
  assign result.effective_mask = head.effective_mask;

endmodule

`default_nettype wire

[src/pisc_checker.sv]
`default_nettype none

module pisc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  read_data,
  input wire logic [23:0] local_dispatch,
  input wire logic        update_request,
  input wire logic [7:0]  effective_mask
);

  // An accepted transaction always shows a result on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted transaction");

  // A write result carries neither read data nor dispatch bits.
  a_write_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && update_request |-> read_data == 8'd0 && local_dispatch == 24'd0)
    else $error("write result carries read or dispatch data");

  // Effective mask only accompanies an update request.
  a_eff_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && effective_mask != 8'd0 |-> update_request)
    else $error("effective mask without update request");

  // Dispatch bits come only from events, which return no read data.
  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && local_dispatch != 24'd0 |-> read_data == 8'd0 && !update_request)
    else $error("dispatch mixed with read or write result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind pmic_interrupt_shadow_controller pisc_checker u_pisc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (request.valid),
  .in_ready       (request.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .read_data      (result.read_data),
  .local_dispatch (result.local_dispatch),
  .update_request (result.update_request),
  .effective_mask (result.effective_mask)
);

`default_nettype wire
